// ===== design/eis_pkg.sv =====
// Shared types and constants for the ellipse inlier scoring block.
package eis_pkg;

    localparam int DEFAULT_MAX_POINTS = 65535;
    localparam int QUEUE_DEPTH        = 4;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_COS_ROT     = 3'd2,
        REG_SIN_ROT     = 3'd3,
        REG_INV_MAJOR   = 3'd4,
        REG_INV_MINOR   = 3'd5,
        REG_SEMI_MINOR  = 3'd6,
        REG_THRESHOLD   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [17:0] center_x;
        logic signed [17:0] center_y;
        logic signed [15:0] cos_rot;
        logic signed [15:0] sin_rot;
        logic [31:0]        inv_major_sq;
        logic [31:0]        inv_minor_sq;
        logic [15:0]        semi_minor;
        logic [15:0]        inlier_threshold;
    } t_cfg;

    typedef struct packed {
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic        last_point;
    } t_point;

    // rotated point, Q.4, as handed from front to back
    typedef struct packed {
        logic signed [21:0] qx;
        logic signed [21:0] qy;
        logic               last;
    } t_qitem;

    typedef struct packed {
        logic        inlier;
        logic [15:0] distance;
        logic [15:0] inlier_total;
        logic [31:0] error_total;
        logic        end_of_set;
    } t_result;

endpackage

// ===== design/eis_front.sv =====
// Front end: centre shift, rotation and rounding of each edge point.
module eis_front import eis_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cfg                           i_cfg,
    input  logic                           push,
    output logic                           full,
    input  t_point                         i_point,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] i_q_count,
    output logic                           o_wr,
    output t_qitem                         o_wr_data
);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    logic               r_v1, r_v2, r_l1, r_l2;
    logic signed [18:0] r_px, r_py;
    logic signed [34:0] r_cpx, r_spy, r_spx, r_cpy;
    logic [CW:0]        in_flight;
    logic signed [35:0] sum_x, sum_y;
    logic               accept;

    // queue slots already spoken for by items in the pipeline
    assign in_flight = {1'b0, i_q_count} + (CW+1)'(r_v1) + (CW+1)'(r_v2);
    assign full      = in_flight >= (CW+1)'(QUEUE_DEPTH);
    assign accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
        r_px  <= $signed({3'b000, i_point.point_x}) - {i_cfg.center_x[17], i_cfg.center_x};
        r_py  <= $signed({3'b000, i_point.point_y}) - {i_cfg.center_y[17], i_cfg.center_y};
        r_l1  <= i_point.last_point;
        r_cpx <= i_cfg.cos_rot * r_px;
        r_spy <= i_cfg.sin_rot * r_py;
        r_spx <= i_cfg.sin_rot * r_px;
        r_cpy <= i_cfg.cos_rot * r_py;
        r_l2  <= r_l1;
    end

    // round half up from Q.18 to Q.4
    assign sum_x = {r_cpx[34], r_cpx} - {r_spy[34], r_spy} + 36'sd8192;
    assign sum_y = {r_spx[34], r_spx} + {r_cpy[34], r_cpy} + 36'sd8192;

    assign o_wr           = r_v2;
    assign o_wr_data.qx   = sum_x[35:14];
    assign o_wr_data.qy   = sum_y[35:14];
    assign o_wr_data.last = r_l2;

endmodule

// ===== design/eis_queue.sv =====
// Short queue of rotated points between front and back.
module eis_queue import eis_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  t_qitem                           i_wr_data,
    input  logic                             i_rd,
    output t_qitem                           o_rd_data,
    output logic                             o_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_count
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    t_qitem          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) r_wp <= (r_wp == AW'(QUEUE_DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_rd) r_rp <= (r_rp == AW'(QUEUE_DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_count <= r_count + CW'(i_wr) - CW'(i_rd);
        end
        if (i_wr) r_mem[r_wp] <= i_wr_data;
    end

    assign o_rd_data = r_mem[r_rp];
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(QUEUE_DEPTH)) |-> !i_wr || i_rd)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("queue read while empty");

endmodule

// ===== design/eis_back.sv =====
// Back end: distance sequencer over one shared multiplier, scoring and result register.
module eis_back import eis_pkg::*; #(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_qitem  i_item,
    input  logic    i_item_empty,
    output logic    o_item_rd,
    output t_result o_result,
    output logic    empty,
    input  logic    pop
);
    typedef enum logic [4:0] {
        ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7, ST_M8, ST_M9,
        ST_NORM, ST_SQ1, ST_SQ2, ST_SQ3, ST_ROOT, ST_DCHK, ST_DIV, ST_DONE
    } t_state;

    localparam logic [64:0] ONE_Q32 = 65'h1_0000_0000;

    t_state         r_state;
    logic [21:0]    r_ax, r_ay;
    logic           r_last, r_sat;
    logic [43:0]    r_sqx, r_sqy, r_ph;
    logic [63:0]    r_pl, r_ex, r_ey, r_e, r_n;
    logic [53:0]    r_sx, r_sy;
    logic signed [6:0] r_k;
    logic [63:0]    r_ssx, r_ssy, r_rad, r_root, r_bit, r_num;
    logic [47:0]    r_rem, r_dv;
    logic [15:0]    r_quo, r_dist, r_count;
    logic [3:0]     r_cnt;
    logic [31:0]    r_sum;
    t_result        r_out;
    logic           r_out_valid;

    logic [31:0]    mul_a, mul_b;
    logic [63:0]    mul_p;
    logic [21:0]    in_ax, in_ay;
    logic [53:0]    mx;
    logic [64:0]    e_sum;
    logic signed [6:0] sh;
    logic [127:0]   wide;
    logic [63:0]    trial;
    logic           inl, take;
    logic [32:0]    sum_next;

    // Q.32 product of squared coordinate and inverse square, floored by 7 bits
    function automatic logic [63:0] scale_q7(input logic [43:0] ph, input logic [63:0] pl);
        logic [76:0] t;
        t = {1'b0, ph, 32'b0} + {13'b0, pl};
        return (t[76:71] != '0) ? '1 : t[70:7];
    endfunction

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_M1:  begin mul_a = {10'b0, r_ax}; mul_b = {10'b0, r_ax}; end
            ST_M2:  begin mul_a = {10'b0, r_ay}; mul_b = {10'b0, r_ay}; end
            ST_M3:  begin mul_a = r_sqx[31:0]; mul_b = i_cfg.inv_major_sq; end
            ST_M4:  begin mul_a = {20'b0, r_sqx[43:32]}; mul_b = i_cfg.inv_major_sq; end
            ST_M5:  begin mul_a = r_sqy[31:0]; mul_b = i_cfg.inv_minor_sq; end
            ST_M6:  begin mul_a = {20'b0, r_sqy[43:32]}; mul_b = i_cfg.inv_minor_sq; end
            ST_M7:  begin mul_a = {10'b0, r_ax}; mul_b = i_cfg.inv_major_sq; end
            ST_M8:  begin mul_a = {10'b0, r_ay}; mul_b = i_cfg.inv_minor_sq; end
            ST_SQ1: begin mul_a = r_sx[31:0]; mul_b = r_sx[31:0]; end
            ST_SQ2: begin mul_a = r_sy[31:0]; mul_b = r_sy[31:0]; end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign in_ax = i_item.qx[21] ? 22'(-i_item.qx) : i_item.qx;
    assign in_ay = i_item.qy[21] ? 22'(-i_item.qy) : i_item.qy;
    assign mx    = (r_sx > r_sy) ? r_sx : r_sy;
    assign e_sum = {1'b0, r_ex} + {1'b0, r_ey};
    assign sh    = 7'sd6 - r_k;
    assign wide  = {64'b0, r_n} << sh[5:0];
    assign trial = r_root + r_bit;

    assign o_item_rd = (r_state == ST_IDLE) && !i_item_empty;
    assign inl       = !r_sat && (r_dist <= i_cfg.inlier_threshold);
    assign take      = (r_state == ST_DONE) && (!r_out_valid || pop);
    assign sum_next  = {1'b0, r_sum} + {17'b0, r_dist};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (!i_item_empty) begin
                    r_ax   <= in_ax;
                    r_ay   <= in_ay;
                    r_last <= i_item.last;
                    r_sat  <= 1'b0;
                    if (i_item.qx == '0 && i_item.qy == '0) begin
                        r_dist  <= i_cfg.semi_minor;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_M1;
                    end
                end
                ST_M1: begin r_sqx <= mul_p[43:0]; r_state <= ST_M2; end
                ST_M2: begin r_sqy <= mul_p[43:0]; r_state <= ST_M3; end
                ST_M3: begin r_pl  <= mul_p; r_state <= ST_M4; end
                ST_M4: begin r_ph  <= mul_p[43:0]; r_state <= ST_M5; end
                ST_M5: begin
                    r_ex    <= scale_q7(r_ph, r_pl);
                    r_pl    <= mul_p;
                    r_state <= ST_M6;
                end
                ST_M6: begin r_ph <= mul_p[43:0]; r_state <= ST_M7; end
                ST_M7: begin
                    r_ey    <= scale_q7(r_ph, r_pl);
                    r_sx    <= mul_p[53:0];
                    r_state <= ST_M8;
                end
                ST_M8: begin
                    r_e     <= e_sum[64] ? '1 : e_sum[63:0];
                    r_sy    <= mul_p[53:0];
                    r_state <= ST_M9;
                end
                ST_M9: begin
                    r_n <= ({1'b0, r_e} >= ONE_Q32) ? 64'({1'b0, r_e} - ONE_Q32)
                                                    : 64'(ONE_Q32 - {1'b0, r_e});
                    r_k <= '0;
                    if (r_sx == '0 && r_sy == '0) begin
                        // zero gradient: distance unbounded
                        r_sat   <= 1'b1;
                        r_dist  <= '1;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // bring the larger gradient into [2^30, 2^31)
                    if (mx[53:31] != '0) begin
                        r_sx <= r_sx >> 1;
                        r_sy <= r_sy >> 1;
                        r_k  <= r_k + 7'sd1;
                    end else if (!mx[30]) begin
                        r_sx <= r_sx << 1;
                        r_sy <= r_sy << 1;
                        r_k  <= r_k - 7'sd1;
                    end else begin
                        r_state <= ST_SQ1;
                    end
                end
                ST_SQ1: begin r_ssx <= mul_p; r_state <= ST_SQ2; end
                ST_SQ2: begin r_ssy <= mul_p; r_state <= ST_SQ3; end
                ST_SQ3: begin
                    r_rad  <= r_ssx + r_ssy;
                    r_root <= '0;
                    r_bit  <= 64'h4000_0000_0000_0000;
                    if (sh[6]) begin
                        r_num   <= r_n >> 6'(-sh);
                        r_state <= ST_ROOT;
                    end else if (wide[127:64] != '0) begin
                        r_sat   <= 1'b1;
                        r_dist  <= '1;
                        r_state <= ST_DONE;
                    end else begin
                        r_num   <= wide[63:0];
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (r_rad >= trial) begin
                        r_rad  <= r_rad - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) r_state <= ST_DCHK;
                end
                ST_DCHK: begin
                    // quotient above 16 bits saturates
                    if (r_num >= {16'b0, r_root[31:0], 16'b0}) begin
                        r_sat   <= 1'b1;
                        r_dist  <= '1;
                        r_state <= ST_DONE;
                    end else begin
                        r_rem   <= r_num[47:0];
                        r_dv    <= {1'b0, r_root[31:0], 15'b0};
                        r_cnt   <= 4'd15;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_rem >= r_dv) begin
                        r_rem <= r_rem - r_dv;
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_dv  <= r_dv >> 1;
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) r_state <= ST_DONE;
                end
                ST_DONE: if (take) begin
                    r_out.inlier       <= inl;
                    r_out.distance     <= r_dist;
                    r_out.end_of_set   <= r_last;
                    r_out.inlier_total <= (inl && r_count < 16'(MAX_POINTS))
                                          ? r_count + 16'd1 : r_count;
                    r_out.error_total  <= !inl ? r_sum : (sum_next[32] ? '1 : sum_next[31:0]);
                    if (r_last) begin
                        r_count <= '0;
                        r_sum   <= '0;
                    end else if (inl) begin
                        if (r_count < 16'(MAX_POINTS)) r_count <= r_count + 16'd1;
                        r_sum <= sum_next[32] ? '1 : sum_next[31:0];
                    end
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
            // result register fills on a take, empties on a pop
            if (take) r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
            // quotient lands after the final divide step
            if (r_state == ST_DIV && r_cnt == 4'd0)
                r_dist <= {r_quo[14:0], (r_rem >= r_dv)};
        end
    end

    assign o_result = r_out;
    assign empty    = !r_out_valid;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 16'(MAX_POINTS))
        else $error("inlier count beyond limit");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_last) |=> (r_count == '0 && r_sum == '0))
        else $error("accumulators not cleared after set end");
    a_sat_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_sat) |-> (r_dist == 16'hFFFF))
        else $error("saturated distance not at full scale");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < {r_dv[46:0], 1'b0}))
        else $error("divider remainder out of range");

endmodule

// ===== design/ellipse_inlier_scoring.sv =====
// Top level: configuration registers, front end, point queue and back-end sequencer.
//
//  channel   dir   handshake            payload
//  point     in    push / full          i_point (t_point)
//  result    out   empty / pop          o_result (t_result)
//  config    in    i_cfg_we             i_cfg_idx, i_cfg_data
//
// A point passes the front pipeline (centre shift, then rotation products) into
// the queue; the back-end sequencer then runs 10 products on the shared 32x32
// multiplier, up to 30 normalisation shifts, 32 square-root steps and 16 divide
// steps; a point at the centre skips them. Sustained rate is set by the back end.
// Reset is synchronous; the queue holds four points so the front keeps taking
// points while the back end works or a result waits to be popped.
module ellipse_inlier_scoring import eis_pkg::*; #(
    parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_point                i_point,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW = $clog2(QUEUE_DEPTH+1);

    t_cfg          r_cfg;
    logic          q_wr, q_rd, q_empty;
    t_qitem        q_wr_data, q_rd_data;
    logic [CW-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x         <= '0;
            r_cfg.center_y         <= '0;
            r_cfg.cos_rot          <= 16'sd16384;
            r_cfg.sin_rot          <= '0;
            r_cfg.inv_major_sq     <= '0;
            r_cfg.inv_minor_sq     <= '0;
            r_cfg.semi_minor       <= '0;
            r_cfg.inlier_threshold <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_CENTER_X:   r_cfg.center_x         <= i_cfg_data[17:0];
                REG_CENTER_Y:   r_cfg.center_y         <= i_cfg_data[17:0];
                REG_COS_ROT:    r_cfg.cos_rot          <= i_cfg_data[15:0];
                REG_SIN_ROT:    r_cfg.sin_rot          <= i_cfg_data[15:0];
                REG_INV_MAJOR:  r_cfg.inv_major_sq     <= i_cfg_data;
                REG_INV_MINOR:  r_cfg.inv_minor_sq     <= i_cfg_data;
                REG_SEMI_MINOR: r_cfg.semi_minor       <= i_cfg_data[15:0];
                REG_THRESHOLD:  r_cfg.inlier_threshold <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    eis_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .push      (push),
        .full      (full),
        .i_point   (i_point),
        .i_q_count (q_count),
        .o_wr      (q_wr),
        .o_wr_data (q_wr_data)
    );

    eis_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (q_wr),
        .i_wr_data (q_wr_data),
        .i_rd      (q_rd),
        .o_rd_data (q_rd_data),
        .o_empty   (q_empty),
        .o_count   (q_count)
    );

    eis_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item       (q_rd_data),
        .i_item_empty (q_empty),
        .o_item_rd    (q_rd),
        .o_result     (o_result),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

// ===== tb/sv/tb_ellipse_inlier_scoring.sv =====
// Testbench for ellipse_inlier_scoring: randomised point streams checked against an in-bench predictor.
module tb_ellipse_inlier_scoring;
    import eis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  SETTLE       = 150;
    localparam real PI           = 3.14159265358979;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    t_point                i_point = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ellipse_inlier_scoring dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_point   points_to_send[$];
    t_result  scores_due[$];
    t_cfg     ellipse_cfg;
    logic [15:0] inlier_count;
    logic [31:0] distance_sum;
    int  errors = 0;
    bit  running = 0;
    bit  point_taken = 0;
    bit  score_taken = 0;
    bit  calm_send = 0;
    bit  calm_recv = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  cycles = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // floor(a*b/128), saturated to 64 bits
    function automatic longint unsigned scaled_product(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 7;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic t_result score_point(t_point pt);
        longint px, py, co, si, qx, qy;
        longint unsigned ax, ay, ex, ey, e, n, gx, gy, mx, sx, sy, m, num, q, ia, ib;
        longint unsigned one;
        logic [15:0] pt_dist;
        bit sat, inl;
        int k, sh;
        t_result r;
        one = 64'd1 << 32;
        ia = ellipse_cfg.inv_major_sq;
        ib = ellipse_cfg.inv_minor_sq;
        px = longint'(pt.point_x) - longint'(ellipse_cfg.center_x);
        py = longint'(pt.point_y) - longint'(ellipse_cfg.center_y);
        co = ellipse_cfg.cos_rot;
        si = ellipse_cfg.sin_rot;
        qx = (co * px - si * py + 8192) >>> 14;
        qy = (si * px + co * py + 8192) >>> 14;
        sat = 0;
        pt_dist = 0;
        if (qx == 0 && qy == 0) begin
            pt_dist = ellipse_cfg.semi_minor;
        end else begin
            ax = (qx < 0) ? -qx : qx;
            ay = (qy < 0) ? -qy : qy;
            ex = scaled_product(ax * ax, ia);
            ey = scaled_product(ay * ay, ib);
            e = (ex > ~ey) ? 64'hFFFF_FFFF_FFFF_FFFF : ex + ey;
            n = (e >= one) ? e - one : one - e;
            gx = ax * ia;
            gy = ay * ib;
            mx = (gx > gy) ? gx : gy;
            if (mx == 0) begin
                sat = 1;
            end else begin
                k = 0;
                while (mx >= (64'd1 << 31)) begin mx >>= 1; k++; end
                while (mx < (64'd1 << 30)) begin mx <<= 1; k--; end
                if (k >= 0) begin sx = gx >> k; sy = gy >> k; end
                else begin sx = gx << (-k); sy = gy << (-k); end
                m = int_sqrt(sx * sx + sy * sy);
                sh = 6 - k;
                num = 0;
                if (sh >= 0) begin
                    if (sh > 0 && (n >> (64 - sh)) != 0) sat = 1;
                    else num = n << sh;
                end else begin
                    num = n >> (-sh);
                end
                if (!sat) begin
                    q = num / m;
                    if (q > 65535) sat = 1;
                    else pt_dist = q[15:0];
                end
            end
            if (sat) pt_dist = 16'hFFFF;
        end
        inl = !sat && pt_dist <= ellipse_cfg.inlier_threshold;
        if (inl) begin
            if (inlier_count < 16'(DEFAULT_MAX_POINTS)) inlier_count++;
            distance_sum = ({1'b0, distance_sum} + pt_dist > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                           : distance_sum + pt_dist;
        end
        r.inlier       = inl;
        r.distance     = pt_dist;
        r.inlier_total = inlier_count;
        r.error_total  = distance_sum;
        r.end_of_set   = pt.last_point;
        if (pt.last_point) begin
            inlier_count = 0;
            distance_sum = 0;
        end
        return r;
    endfunction

    // input side: accepted transfers feed the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            scores_due.push_back(score_point(i_point));
            point_taken = 1;
        end
    end

    // output side
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            score_taken = 1;
            if (scores_due.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, o_result);
                errors++;
            end else begin
                want = scores_due.pop_front();
                if (want.inlier !== o_result.inlier)
                    $display("%0t: inlier exp %0d got %0d", $realtime, want.inlier,
                             o_result.inlier);
                if (want.distance !== o_result.distance)
                    $display("%0t: distance exp %0d got %0d", $realtime, want.distance,
                             o_result.distance);
                if (want.inlier_total !== o_result.inlier_total)
                    $display("%0t: inlier_total exp %0d got %0d", $realtime,
                             want.inlier_total, o_result.inlier_total);
                if (want.error_total !== o_result.error_total)
                    $display("%0t: error_total exp %0d got %0d", $realtime,
                             want.error_total, o_result.error_total);
                if (want.end_of_set !== o_result.end_of_set)
                    $display("%0t: end_of_set exp %0d got %0d", $realtime,
                             want.end_of_set, o_result.end_of_set);
                if (want !== o_result) errors++;
            end
        end
    end

    // point driver
    always @(negedge i_clk) begin
        logic nxt;
        nxt = push;
        if (running) begin
            if (push && point_taken) begin
                nxt = 0;
                if ($urandom_range(0, 60) == 0) calm_send = !calm_send;
                send_gap = calm_send ? 0 : $urandom_range(0, 19);
            end
            point_taken = 0;
            if (!nxt) begin
                if (send_gap > 0) send_gap--;
                else if (points_to_send.size() != 0) begin
                    i_point <= points_to_send.pop_front();
                    nxt = 1;
                end
            end
            push <= nxt;
        end
    end

    // result drain with random stalls
    always @(negedge i_clk) begin
        if (running) begin
            if (score_taken) begin
                score_taken = 0;
                if ($urandom_range(0, 60) == 0) calm_recv = !calm_recv;
                recv_gap = calm_recv ? 0 : $urandom_range(0, 19);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_CENTER_X:   ellipse_cfg.center_x = val[17:0];
            REG_CENTER_Y:   ellipse_cfg.center_y = val[17:0];
            REG_COS_ROT:    ellipse_cfg.cos_rot = val[15:0];
            REG_SIN_ROT:    ellipse_cfg.sin_rot = val[15:0];
            REG_INV_MAJOR:  ellipse_cfg.inv_major_sq = val;
            REG_INV_MINOR:  ellipse_cfg.inv_minor_sq = val;
            REG_SEMI_MINOR: ellipse_cfg.semi_minor = val[15:0];
            REG_THRESHOLD:  ellipse_cfg.inlier_threshold = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] c, logic [31:0] s,
                            logic [31:0] ia, logic [31:0] ib, logic [31:0] sm,
                            logic [31:0] th);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_COS_ROT, c);
        write_reg(REG_SIN_ROT, s);
        write_reg(REG_INV_MAJOR, ia);
        write_reg(REG_INV_MINOR, ib);
        write_reg(REG_SEMI_MINOR, sm);
        write_reg(REG_THRESHOLD, th);
    endtask

    task automatic add_point(int x, int y, bit last);
        t_point p;
        p.point_x = (x < 0) ? 16'd0 : (x > 65535) ? 16'hFFFF : 16'(x);
        p.point_y = (y < 0) ? 16'd0 : (y > 65535) ? 16'hFFFF : 16'(y);
        p.last_point = last;
        points_to_send.push_back(p);
    endtask

    task automatic drain;
        while (points_to_send.size() != 0 || push || scores_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        real th, cr, sr, t, ux, uy, nz;
        int  a, b, cx, cy, n;
        ellipse_cfg = '0;
        ellipse_cfg.cos_rot = 16'sd16384;
        inlier_count = 0;
        distance_sum = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1;

        // reset values: zero inverse squares, so only the centre point is finite
        add_point(0, 0, 0);
        add_point(65535, 65535, 0);
        add_point(0, 65535, 0);
        add_point(65535, 0, 1);
        drain();

        // register extremes, overflowed distances against the widest threshold
        load_all(32'h0002_0000, 32'h0001_FFFF, 32'hFFFF_C000, 32'h0000_4000,
                 32'h8000_0000, 32'h0, 32'hFFFF, 32'hFFFF);
        add_point(0, 0, 0);
        add_point(65535, 65535, 0);
        add_point(65535, 0, 0);
        add_point(0, 65535, 1);
        drain();

        // centre hit with maximal semi-minor, plus out-of-range raw register bits
        load_all(1000, 2000, 32'h7FFF, 32'h8000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF,
                 32'hFFFF);
        add_point(1000, 2000, 0);
        add_point(1001, 2000, 0);
        add_point(1000, 1999, 0);
        add_point(40000, 3000, 0);
        add_point(65535, 65535, 1);
        drain();

        // small circle, exact points on it and at the centre
        load_all(16000, 16000, 16384, 0, 32'h0080_0000, 32'h0080_0000, 256, 16);
        add_point(16000, 16000, 0);
        add_point(16000 + 256, 16000, 0);
        add_point(16000, 16000 - 256, 0);
        add_point(16000 + 300, 16000, 0);
        add_point(16000 + 180, 16000 + 181, 0);
        add_point(0, 0, 1);
        drain();

        // random ellipses, mostly points near the outline
        for (int ph = 0; ph < 11; ph++) begin
            th = ($urandom_range(0, 3600) / 3600.0) * 2.0 * PI;
            cr = $cos(th);
            sr = $sin(th);
            a  = (ph % 4 == 0) ? $urandom_range(1, 8) : $urandom_range(2, 600);
            b  = $urandom_range(1, a);
            cx = $urandom_range(300, 3800) * 16;
            cy = $urandom_range(300, 3800) * 16;
            load_all(cx, cy, 32'(longint'(cr * 16384.0)), 32'(-longint'(sr * 16384.0)),
                     32'((64'd1 << 31) / (a * a)), 32'((64'd1 << 31) / (b * b)), b * 16,
                     (ph == 5) ? 32'hFFFF : $urandom_range(0, 160));
            n = $urandom_range(90, 110);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 99) < 85) begin
                    t  = ($urandom_range(0, 10000) / 10000.0) * 2.0 * PI;
                    nz = ($urandom_range(0, 2000) - 1000.0) / 250.0;
                    ux = (a + nz) * $cos(t);
                    uy = (b + nz) * $sin(t);
                    add_point(cx + int'(16.0 * (ux * cr - uy * sr)),
                              cy + int'(16.0 * (ux * sr + uy * cr)),
                              $urandom_range(0, 19) == 0 || i == n - 1);
                end else if ($urandom_range(0, 4) == 0) begin
                    add_point(cx, cy, 0);
                end else begin
                    add_point($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 1));
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
